/* hw/rtl/sha_pkg.sv */
// Shared types, constants and round functions for the SHA-256 byte hasher.
// No dependencies; imported by every module of the block.
package sha_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* hw/rtl/sha_front.sv */
// Input side: takes items, drops idle ones, and queues the rest for the core.
// Depends on sha_pkg.
module sha_front #(
    parameter int P_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  sha_pkg::t_in_item i_item,
    output logic              o_q_valid,
    output sha_pkg::t_in_item o_q_item,
    input  logic              i_q_take
);
    import sha_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_in_item        r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            wr_en, rd_en;

    assign full      = (r_count == CW'(P_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];
    // an item with no byte and no end mark changes nothing
    assign wr_en     = push && !full && (i_item.has_byte || i_item.last);
    assign rd_en     = i_q_take && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/sha_core.sv */
// Back end: block assembly, padding, 64-round compression and digest output buffer.
// Depends on sha_pkg.
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  sha_pkg::t_in_item  i_q_item,
    output logic               o_q_take,
    output logic               o_empty,
    input  logic               i_pop,
    output sha_pkg::t_out_item o_result
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_COMP = 4'b0100,
        S_ADD  = 4'b1000
    } t_state;

    t_state       r_state;
    logic [31:0]  r_hash [8];
    logic [31:0]  r_v    [8];
    logic [31:0]  r_buf  [16];
    logic [31:0]  r_dig  [8];
    logic [5:0]   r_count;
    logic [5:0]   r_round;
    logic [63:0]  r_msg_len;
    logic [63:0]  r_len;
    logic         r_pad_first, r_in_len, r_ret_pad, r_final;
    logic [2:0]   r_len_idx;
    logic         r_out_busy;
    logic [2:0]   r_out_idx;

    logic         wr_byte;
    logic [7:0]   byte_val;
    logic [3:0]   wr_word;
    logic [4:0]   wr_shift;
    logic         pad_len_byte;
    logic [31:0]  t1, t2, w_new;
    logic [31:0]  sums [8];

    assign o_q_take = (r_state == S_IDLE) && i_q_valid;
    assign o_empty  = !r_out_busy;
    assign o_result = '{digest_word: r_dig[r_out_idx], word_index: r_out_idx,
                        last_word: (r_out_idx == 3'd7)};

    // byte source: queue in idle, padding generator in the pad state
    always_comb begin
        pad_len_byte = 1'b0;
        wr_byte      = 1'b0;
        byte_val     = i_q_item.data_byte;
        if (r_state == S_IDLE) begin
            wr_byte = i_q_valid && i_q_item.has_byte;
        end else if (r_state == S_PAD) begin
            wr_byte = 1'b1;
            if (r_pad_first) begin
                byte_val = PAD_BYTE;
            end else if (r_in_len || r_count == LEN_OFFSET) begin
                pad_len_byte = 1'b1;
                byte_val     = r_len[{3'(3'd7 - r_len_idx), 3'b000} +: 8];
            end else begin
                byte_val = 8'h00;
            end
        end
    end

    assign wr_word  = r_count[5:2];
    assign wr_shift = {~r_count[1:0], 3'b000};

    assign t1 = r_v[7] + big1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + K_TABLE[r_round] + r_buf[0];
    assign t2 = big0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = sig1(r_buf[14]) + r_buf[9] + sig0(r_buf[1]) + r_buf[0];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sums[i] = r_hash[i] + r_v[i];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (wr_byte) begin
            if (r_count[1:0] == 2'b00) begin
                r_buf[wr_word] <= {byte_val, 24'h0};
            end else begin
                r_buf[wr_word] <= r_buf[wr_word] | (32'(byte_val) << wr_shift);
            end
        end
        if (r_state == S_COMP) begin
            // window slides one word per round
            for (int i = 0; i < 15; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
            r_buf[15] <= w_new;
            for (int i = 0; i < 8; i++) begin
                if (i != 0 && i != 4) begin
                    r_v[i] <= r_v[i - 1];
                end
            end
            r_v[0] <= t1 + t2;
            r_v[4] <= r_v[3] + t1;
        end
        if (wr_byte && r_count == 6'd63) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
        end
        if (r_state == S_ADD && r_final && !r_out_busy) begin
            for (int i = 0; i < 8; i++) begin
                r_dig[i] <= sums[i];
            end
        end
        if (o_q_take && i_q_item.last) begin
            r_len <= r_msg_len + (i_q_item.has_byte ? 64'd8 : 64'd0);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_round     <= '0;
            r_msg_len   <= '0;
            r_pad_first <= 1'b0;
            r_in_len    <= 1'b0;
            r_len_idx   <= '0;
            r_ret_pad   <= 1'b0;
            r_final     <= 1'b0;
            r_out_busy  <= 1'b0;
            r_out_idx   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= IV_TABLE[i];
            end
        end else begin
            if (i_pop && r_out_busy) begin
                r_out_idx <= r_out_idx + 1'b1;
                if (r_out_idx == 3'd7) begin
                    r_out_busy <= 1'b0;
                end
            end
            if (wr_byte) begin
                r_count <= r_count + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_item.last) begin
                            r_msg_len   <= '0;
                            r_pad_first <= 1'b1;
                            r_in_len    <= 1'b0;
                            r_len_idx   <= '0;
                        end else if (i_q_item.has_byte) begin
                            r_msg_len <= r_msg_len + 64'd8;
                        end
                        if (wr_byte && r_count == 6'd63) begin
                            r_state   <= S_COMP;
                            r_round   <= '0;
                            r_ret_pad <= i_q_item.last;
                            r_final   <= 1'b0;
                        end else if (i_q_item.last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pad_first <= 1'b0;
                    if (pad_len_byte) begin
                        r_in_len  <= 1'b1;
                        r_len_idx <= r_len_idx + 1'b1;
                    end
                    if (r_count == 6'd63) begin
                        r_state   <= S_COMP;
                        r_round   <= '0;
                        r_final   <= pad_len_byte && (r_len_idx == 3'd7);
                        r_ret_pad <= !(pad_len_byte && (r_len_idx == 3'd7));
                    end
                end
                S_COMP: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (!r_final) begin
                        for (int i = 0; i < 8; i++) begin
                            r_hash[i] <= sums[i];
                        end
                        r_state <= r_ret_pad ? S_PAD : S_IDLE;
                    end else if (!r_out_busy) begin
                        for (int i = 0; i < 8; i++) begin
                            r_hash[i] <= IV_TABLE[i];
                        end
                        r_out_busy <= 1'b1;
                        r_out_idx  <= '0;
                        r_count    <= '0;
                        r_final    <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte hasher: input queue feeding the compression core.
// Depends on sha_pkg, sha_front and sha_core.
//
// Bytes enter one per item and are packed into a 64-byte block at one byte per
// cycle while the core is idle; a full block then holds the core for 64 rounds
// through one shared round unit plus the final hash add, during which the input
// queue keeps accepting until its P_QUEUE_DEPTH entries are full. An item marked
// last starts padding, one padding byte per cycle up to the next block end, then
// one or two compressions; the eight digest words follow from an output buffer,
// h0 first, one per pop. The next message may stream in while the digest drains;
// its own final hash add waits until the previous digest has been fully popped.
module sha256_byte_stream_hasher #(
    parameter int P_QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sha_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output sha_pkg::t_out_item o_result
);
    import sha_pkg::*;

    logic     q_valid, q_take;
    t_in_item q_item;

    sha_front #(.P_DEPTH(P_QUEUE_DEPTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_take  (q_take)
    );

    sha_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_take  (q_take),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && o_result.word_index != 3'd7 |=>
            !empty && o_result.word_index == $past(o_result.word_index) + 3'd1)
        else $error("digest words out of order");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.last_word == (o_result.word_index == 3'd7))
        else $error("last_word mismatch");

    a_start_word0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(!empty) |-> o_result.word_index == 3'd0)
        else $error("digest does not start at word 0");

endmodule
